### rtl/npss_pkg.sv
// Shared types and constants for the nearest-point-on-segment-set core.
package npss_pkg;

    localparam int SEG_SLOT_BITS = 6;
    localparam int CFG_BITS      = 7;
    localparam int SQ_BITS       = 33;
    localparam int DIST_BITS     = 17;
    localparam int FRAC_BITS     = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_READ  = 11'b00000000010,
        ST_DIFF  = 11'b00000000100,
        ST_MUL   = 11'b00000001000,
        ST_DIV   = 11'b00000010000,
        ST_OFFS  = 11'b00000100000,
        ST_DIST  = 11'b00001000000,
        ST_CMP   = 11'b00010000000,
        ST_SQRT  = 11'b00100000000,
        ST_EMIT  = 11'b01000000000,
        ST_WAIT  = 11'b10000000000
    } state_t;

endpackage

### rtl/npss_ram.sv
// Generic single-port-write, registered-read RAM.
module npss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/nearest_point_on_segment_set_core.sv
// Top level: nearest point on a table of 2D segments, one shared unit under a sequencer.
// Load: written at the accept edge; busy never rises, so loads can follow back to back.
// Query over N segments: each segment runs fetch (wait, read, diff), 4 multiply steps,
//   a restoring divide, 4 offset, 3 distance and 1 compare step; then the root is taken
//   and the tie scan walks all N segments.
// Each tied segment strobes result_valid the cycle after its scan cycle; receiver cannot stall.
// Async active-low rst_n clears control state and ties; best = all ones, segment_count = 1.
module nearest_point_on_segment_set_core
    import npss_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cfg_we,
    input  logic [CFG_BITS-1:0]          cfg_data,
    input  logic                         op,
    input  logic [SEG_SLOT_BITS-1:0]     seg_slot,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    output logic                         result_valid,
    output logic signed [COORD_BITS-1:0] near_x,
    output logic signed [COORD_BITS-1:0] near_y,
    output logic [SQ_BITS-1:0]           squared_distance,
    output logic [DIST_BITS-1:0]         distance,
    output logic [SEG_SLOT_BITS-1:0]     tied_segment,
    output logic                         last
);
    localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW   = $clog2(MAX_SEGMENTS + 1);
    localparam int DW   = COORD_BITS + 1;          // difference width
    localparam int PW   = 2 * DW;                  // product width
    localparam int C2W  = PW + 1;                  // dot product width
    localparam int DSQ  = 2 * DW + 1;              // squared distance width
    localparam int SQW  = DSQ + 1;                 // best with headroom
    localparam int RW   = (DSQ + 1) / 2;           // root width
    localparam int SQ_STEPS = (DSQ + 1) / 2;
    localparam int SEGW = 4 * COORD_BITS;

    // ---------------- segment table ----------------
    logic            ram_we;
    logic [AW-1:0]   ram_raddr;
    logic [SEGW-1:0] ram_rdata;
    logic            slot_ok;

    assign slot_ok = ({{(32-SEG_SLOT_BITS){1'b0}}, seg_slot} < MAX_SEGMENTS);
    assign ram_we  = start && !busy && (op == OP_LOAD) && slot_ok;

    npss_ram #(.WIDTH(SEGW), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(seg_slot)),
        .wdata ({start_x, start_y, end_x, end_y}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- registers ----------------
    state_t                   state_reg, state_next;
    logic [CFG_BITS-1:0]      count_cfg_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            idx_reg, idx_next;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DW-1:0]     vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [C2W-1:0]    c1_reg, c2_reg;
    logic [1:0]               mstep_reg;        // shared multiplier step
    logic signed [PW-1:0]     prod_reg;
    logic [C2W-1:0]           rem_reg;          // divider remainder
    logic [FRAC_BITS-1:0]     quo_reg;          // b
    logic [4:0]               dcnt_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic [DSQ-1:0]           d2_reg;
    logic [SQW-1:0]           best_reg;
    logic signed [COORD_BITS-1:0] bpx_reg, bpy_reg;
    logic [MAX_SEGMENTS-1:0]  ties_reg;
    logic [DSQ-1:0]           sqx_reg;
    logic [DSQ:0]             sqr_reg;          // partial root, scaled by the current bit
    logic [DSQ:0]             sqb_reg;
    logic [5:0]               scnt_reg;
    logic [RW-1:0]            root_reg;
    logic [CW-1:0]            lastidx_reg;
    logic [CW-1:0]            last_tie;

    // shared multiplier: one signed DW x DW product per cycle
    logic signed [DW-1:0] ma, mb;
    logic signed [PW-1:0] mprod;
    assign mprod = ma * mb;

    logic signed [DW-1:0] dxq, dyq;
    assign dxq = DW'(qx_reg) - DW'(px_reg);
    assign dyq = DW'(qy_reg) - DW'(py_reg);

    always_comb
    begin
        ma = vx_reg;
        mb = vx_reg;
        case (state_reg)
            ST_MUL:
            begin
                case (mstep_reg)
                    2'd0:    begin ma = wx_reg; mb = vx_reg; end
                    2'd1:    begin ma = wy_reg; mb = vy_reg; end
                    2'd2:    begin ma = vx_reg; mb = vx_reg; end
                    default: begin ma = vy_reg; mb = vy_reg; end
                endcase
            end
            ST_OFFS:
            begin
                ma = $signed({1'b0, quo_reg});
                mb = mstep_reg[0] ? vy_reg : vx_reg;
            end
            ST_DIST:
            begin
                ma = mstep_reg[0] ? dyq : dxq;
                mb = mstep_reg[0] ? dyq : dxq;
            end
            default: ;
        endcase
    end

    // rounded offset: floor((b*v + 2^15) / 2^16); product fits PW bits (b < 2^16)
    logic signed [PW:0]         rnd_sum;
    logic signed [COORD_BITS-1:0] offs;
    assign rnd_sum = {prod_reg[PW-1], prod_reg} + (PW+1)'(1 << (FRAC_BITS-1));
    assign offs    = COORD_BITS'(rnd_sum >>> FRAC_BITS);

    // divider step: shift-subtract
    logic [C2W:0] dshift;
    logic         dge;
    assign dshift = {rem_reg, 1'b0};
    assign dge    = (dshift >= {1'b0, c2_reg});

    // sqrt step
    logic [DSQ+1:0] sq_trial;
    assign sq_trial = (DSQ+2)'(sqr_reg) + (DSQ+2)'(sqb_reg);

    // highest marked segment, for the last flag
    always_comb
    begin
        last_tie = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
        begin
            if (ties_reg[i]) last_tie = CW'(i);
        end
    end

    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (count_cfg_reg == '0)
            n_eff = CW'(1);
        else if ({{(32-CFG_BITS){1'b0}}, count_cfg_reg} > MAX_SEGMENTS)
            n_eff = CW'(MAX_SEGMENTS);
        else
            n_eff = CW'(count_cfg_reg);
    end

    assign ram_raddr = idx_reg[AW-1:0];
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:  if (start && op == OP_QUERY) state_next = ST_WAIT;
            ST_WAIT:  state_next = ST_READ;
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   if (mstep_reg == 2'd3) state_next = ST_DIV;
            ST_DIV:   if (dcnt_reg == 5'd0) state_next = ST_OFFS;
            ST_OFFS:  if (mstep_reg == 2'd3) state_next = ST_DIST;
            ST_DIST:  if (mstep_reg == 2'd2) state_next = ST_CMP;
            ST_CMP:
            begin
                if (idx_reg + CW'(1) == n_reg)
                begin
                    state_next = ST_SQRT;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_WAIT;
                end
            end
            ST_SQRT:  if (scnt_reg == 6'd0) state_next = ST_EMIT;
            ST_EMIT:
            begin
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) == n_reg) state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE) idx_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_cfg_reg <= CFG_BITS'(1);
            idx_reg       <= '0;
            mstep_reg     <= '0;
            dcnt_reg      <= '0;
            scnt_reg      <= '0;
            best_reg      <= '1;
            bpx_reg       <= '0;
            bpy_reg       <= '0;
            ties_reg      <= '0;
            result_valid  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            result_valid <= (state_reg == ST_EMIT) && ties_reg[idx_reg[AW-1:0]];
            if (cfg_we) count_cfg_reg <= cfg_data;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start && op == OP_QUERY)
                    begin
                        best_reg <= '1;
                        ties_reg <= '0;
                    end
                end
                ST_DIFF:  mstep_reg <= '0;
                ST_MUL:
                begin
                    // step counter wraps to zero after the fourth product
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd3) dcnt_reg <= 5'(FRAC_BITS);
                end
                ST_DIV:
                begin
                    if (dcnt_reg != 5'd0) dcnt_reg <= dcnt_reg - 5'd1;
                    else mstep_reg <= '0;
                end
                ST_OFFS:  mstep_reg <= mstep_reg + 2'd1;
                ST_DIST:  mstep_reg <= mstep_reg + 2'd1;
                ST_CMP:
                begin
                    if ({1'b0, d2_reg} < best_reg)
                    begin
                        best_reg <= {1'b0, d2_reg};
                        bpx_reg  <= px_reg;
                        bpy_reg  <= py_reg;
                        ties_reg <= MAX_SEGMENTS'(1) << idx_reg[AW-1:0];
                    end
                    else if ({1'b0, d2_reg} == best_reg)
                    begin
                        ties_reg[idx_reg[AW-1:0]] <= 1'b1;
                    end
                    scnt_reg <= 6'(SQ_STEPS + 1);
                end
                ST_SQRT:  if (scnt_reg != 6'd0) scnt_reg <= scnt_reg - 6'd1;
                default: ;
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= query_x;
                qy_reg <= query_y;
                n_reg  <= n_eff;
            end
            ST_READ:
            begin
                {sx_reg, sy_reg, ex_reg, ey_reg} <= ram_rdata;
            end
            ST_DIFF:
            begin
                vx_reg <= DW'(ex_reg) - DW'(sx_reg);
                vy_reg <= DW'(ey_reg) - DW'(sy_reg);
                wx_reg <= DW'(qx_reg) - DW'(sx_reg);
                wy_reg <= DW'(qy_reg) - DW'(sy_reg);
                c1_reg <= '0;
                c2_reg <= '0;
            end
            ST_MUL:
            begin
                if (mstep_reg[1]) c2_reg <= c2_reg + C2W'(mprod);
                else c1_reg <= c1_reg + C2W'(mprod);
                rem_reg <= '0;
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                // first cycle (dcnt == FRAC_BITS): rem = c1; quotient used only if 0 < c1 < c2
                if (dcnt_reg == 5'(FRAC_BITS))
                begin
                    rem_reg <= c1_reg;
                end
                else if (dcnt_reg != 5'd0)
                begin
                    quo_reg <= {quo_reg[FRAC_BITS-2:0], dge};
                    rem_reg <= dge ? C2W'(dshift - {1'b0, c2_reg}) : C2W'(dshift);
                end
                else
                begin
                    quo_reg <= {quo_reg[FRAC_BITS-2:0], dge};
                end
            end
            ST_OFFS:
            begin
                // step0: b*vx, step1: x off + b*vy, step2: y off, step3: clamp choice
                prod_reg <= mprod;
                if (mstep_reg == 2'd1) px_reg <= sx_reg + offs;
                if (mstep_reg == 2'd2) py_reg <= sy_reg + offs;
                if (mstep_reg == 2'd3)
                begin
                    if (c1_reg <= 0)
                    begin
                        px_reg <= sx_reg;
                        py_reg <= sy_reg;
                    end
                    else if (c2_reg <= c1_reg)
                    begin
                        px_reg <= ex_reg;
                        py_reg <= ey_reg;
                    end
                end
            end
            ST_DIST:
            begin
                if (mstep_reg == 2'd0) d2_reg <= DSQ'(unsigned'(mprod));
                if (mstep_reg == 2'd1) d2_reg <= d2_reg + DSQ'(unsigned'(mprod));
            end
            ST_CMP:
            begin
                sqr_reg <= '0;
                sqb_reg <= (DSQ+1)'(1) << (2 * (SQ_STEPS - 1));
            end
            ST_SQRT:
            begin
                if (scnt_reg == 6'(SQ_STEPS + 1))
                begin
                    sqx_reg <= best_reg[DSQ-1:0];
                end
                else if (scnt_reg != 6'd0)
                begin
                    if ({1'b0, sqx_reg} >= sq_trial)
                    begin
                        sqx_reg <= DSQ'({1'b0, sqx_reg} - sq_trial);
                        sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                    end
                    else
                    begin
                        sqr_reg <= sqr_reg >> 1;
                    end
                    sqb_reg <= sqb_reg >> 2;
                end
                else
                begin
                    root_reg <= RW'(sqr_reg);
                end
                lastidx_reg <= last_tie;
            end
            ST_EMIT:
            begin
                near_x           <= bpx_reg;
                near_y           <= bpy_reg;
                squared_distance <= SQ_BITS'(best_reg);
                distance         <= DIST_BITS'(root_reg);
                tied_segment     <= SEG_SLOT_BITS'(idx_reg);
                last             <= (idx_reg == lastidx_reg);
            end
            default: ;
        endcase
    end
endmodule

### bench/testbench.sv
// Testbench for nearest_point_on_segment_set_core: directed table plus random load/query traffic.
`timescale 1ns / 100ps

module testbench
    import npss_pkg::*;
();

    localparam int NSEG       = 64;
    localparam int STALL_MAX  = 20000;  // cycles without any transaction before giving up
    localparam int DRAIN_WAIT = 40;     // settle time after the last result

    // one emitted result
    typedef struct {
        logic signed [15:0]       nx;
        logic signed [15:0]       ny;
        logic [SQ_BITS-1:0]       sq;
        logic [DIST_BITS-1:0]     root;
        logic [SEG_SLOT_BITS-1:0] seg;
        logic                     lst;
    } hit_t;

    // one input transaction; cnt_before >= 0 means write segment_count first
    typedef struct {
        int                       cnt_before;
        logic                     kind;
        logic [SEG_SLOT_BITS-1:0] slot;
        logic signed [15:0]       sx, sy, ex, ey, qx, qy;
        bit                       typed;
        hit_t                     want;
    } row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic                         cfg_we;
    logic [CFG_BITS-1:0]          cfg_data;
    logic                         op;
    logic [SEG_SLOT_BITS-1:0]     seg_slot;
    logic signed [15:0]           start_x, start_y, end_x, end_y, query_x, query_y;
    logic                         result_valid;
    logic signed [15:0]           near_x, near_y;
    logic [SQ_BITS-1:0]           squared_distance;
    logic [DIST_BITS-1:0]         distance;
    logic [SEG_SLOT_BITS-1:0]     tied_segment;
    logic                         last;

    nearest_point_on_segment_set_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_data         (cfg_data),
        .op               (op),
        .seg_slot         (seg_slot),
        .start_x          (start_x),
        .start_y          (start_y),
        .end_x            (end_x),
        .end_y            (end_y),
        .query_x          (query_x),
        .query_y          (query_y),
        .result_valid     (result_valid),
        .near_x           (near_x),
        .near_y           (near_y),
        .squared_distance (squared_distance),
        .distance         (distance),
        .tied_segment     (tied_segment),
        .last             (last)
    );

    // shadow copy of the segment table and the count register
    logic signed [15:0] tbl_sx [NSEG];
    logic signed [15:0] tbl_sy [NSEG];
    logic signed [15:0] tbl_ex [NSEG];
    logic signed [15:0] tbl_ey [NSEG];
    int                 seg_count_reg;

    hit_t  expected_hits [$];
    int    mismatches;
    int    idle_cycles;
    bit    accepted_now;
    bit    no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor square root by bit-by-bit build of the root.
    function automatic longint floor_root(longint x);
        longint r;
        longint t;
        r = 0;
        for (int k = 17; k >= 0; k--)
        begin
            t = r | (longint'(1) << k);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // b*v/2^16 rounded to nearest integer (b is Q0.16), halves upward (floor division).
    function automatic longint round_step(longint b, longint v);
        longint num;
        num = b * v + 32768;
        if (num >= 0)
            return num / 65536;
        return -((-num + 65535) / 65536);
    endfunction

    // Walk the searched segments, keep the minimum and its ties, queue the results.
    task automatic predict_nearest(logic signed [15:0] qx, logic signed [15:0] qy);
        longint n, best, d2, vx, vy, wx, wy, c1, c2, b, px, py, bx, by, dx, dy;
        bit     marks [NSEG];
        int     final_idx;
        hit_t   h;
        n = seg_count_reg;
        if (n == 0)
            n = 1;
        if (n > NSEG)
            n = NSEG;
        best = (longint'(1) << 34) - 1;
        bx = 0;
        by = 0;
        final_idx = 0;
        for (int i = 0; i < NSEG; i++)
            marks[i] = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            vx = longint'(tbl_ex[i]) - longint'(tbl_sx[i]);
            vy = longint'(tbl_ey[i]) - longint'(tbl_sy[i]);
            wx = longint'(qx) - longint'(tbl_sx[i]);
            wy = longint'(qy) - longint'(tbl_sy[i]);
            c1 = wx * vx + wy * vy;
            c2 = vx * vx + vy * vy;
            if (c1 <= 0)
            begin
                px = tbl_sx[i];
                py = tbl_sy[i];
            end
            else if (c2 <= c1)
            begin
                px = tbl_ex[i];
                py = tbl_ey[i];
            end
            else
            begin
                b  = (c1 * 65536) / c2;
                px = longint'(tbl_sx[i]) + round_step(b, vx);
                py = longint'(tbl_sy[i]) + round_step(b, vy);
            end
            dx = longint'(qx) - px;
            dy = longint'(qy) - py;
            d2 = dx * dx + dy * dy;
            if (d2 < best)
            begin
                for (int j = 0; j < NSEG; j++)
                    marks[j] = 1'b0;
                marks[i] = 1'b1;
                best = d2;
                bx = px;
                by = py;
            end
            else if (d2 == best)
                marks[i] = 1'b1;
        end
        for (int i = 0; i < n; i++)
            if (marks[i])
                final_idx = i;
        for (int i = 0; i < n; i++)
        begin
            if (marks[i])
            begin
                h.nx   = bx[15:0];
                h.ny   = by[15:0];
                h.sq   = best[SQ_BITS-1:0];
                h.root = DIST_BITS'(floor_root(best));
                h.seg  = SEG_SLOT_BITS'(i);
                h.lst  = (i == final_idx);
                expected_hits = {expected_hits, h};
            end
        end
    endtask

    // Random coordinate: full range, multiples of 256 (ties), or a mid band.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 2))
            0: return 16'($urandom);
            1: return 16'(($urandom_range(0, 8) - 4) * 256);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    // Drive one transaction and hold it until the core takes it.
    task automatic send_transaction(row_t r);
        int gap;
        gap = 0;
        if (!no_idle)
        begin
            case ($urandom_range(0, 19))
                0:             gap = $urandom_range(10, 40);
                1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
                default:       gap = 0;
            endcase
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        op       <= r.kind;
        seg_slot <= r.slot;
        start_x  <= r.sx;
        start_y  <= r.sy;
        end_x    <= r.ex;
        end_y    <= r.ey;
        query_x  <= r.qx;
        query_y  <= r.qy;
        do
            @(posedge clk);
        while (busy);
        if (r.kind == OP_LOAD)
        begin
            tbl_sx[r.slot] = r.sx;
            tbl_sy[r.slot] = r.sy;
            tbl_ex[r.slot] = r.ex;
            tbl_ey[r.slot] = r.ey;
        end
        else if (r.typed)
            expected_hits = {expected_hits, r.want};
        else
            predict_nearest(r.qx, r.qy);
    endtask

    // Let the core go idle, then write segment_count.
    task automatic write_count(int v);
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_hits.size() != 0 || busy);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[CFG_BITS-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        seg_count_reg = v;
    endtask

    function automatic row_t mk(int cb, logic k, int sl, int a, int b, int c, int d,
                                int qx, int qy);
        row_t r;
        r.cnt_before = cb;
        r.kind = k;
        r.slot = SEG_SLOT_BITS'(sl);
        // fields that the operation ignores get random values
        r.sx = (k == OP_LOAD) ? 16'(a) : 16'($urandom);
        r.sy = (k == OP_LOAD) ? 16'(b) : 16'($urandom);
        r.ex = (k == OP_LOAD) ? 16'(c) : 16'($urandom);
        r.ey = (k == OP_LOAD) ? 16'(d) : 16'($urandom);
        r.qx = (k == OP_QUERY) ? 16'(qx) : 16'($urandom);
        r.qy = (k == OP_QUERY) ? 16'(qy) : 16'($urandom);
        if (k == OP_QUERY)
            r.slot = SEG_SLOT_BITS'($urandom);
        r.typed = 1'b0;
        r.want = '{default: '0};
        return r;
    endfunction

    function automatic row_t typed_q(int qx, int qy, int nx, int ny, longint sq, int dist_val);
        row_t r;
        r = mk(-1, OP_QUERY, 0, 0, 0, 0, 0, qx, qy);
        r.typed = 1'b1;
        r.want = '{nx: 16'(nx), ny: 16'(ny), sq: SQ_BITS'(sq), root: DIST_BITS'(dist_val),
                   seg: '0, lst: 1'b1};
        return r;
    endfunction

    // Result checker: every strobe must match the oldest expectation.
    always @(posedge clk)
    begin
        hit_t e;
        if (rst_n && result_valid)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: seg %0d sq %0d", tied_segment,
                             squared_distance);
            end
            else
            begin
                e = expected_hits.pop_front();
                if (near_x !== e.nx || near_y !== e.ny || squared_distance !== e.sq ||
                    distance !== e.root || tied_segment !== e.seg || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp (%0d,%0d) sq %0d d %0d seg %0d last %0d",
                                 e.nx, e.ny, e.sq, e.root, e.seg, e.lst);
                        $display("          got (%0d,%0d) sq %0d d %0d seg %0d last %0d",
                                 near_x, near_y, squared_distance, distance,
                                 tied_segment, last);
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles in which no transaction moves in either direction.
    always @(posedge clk)
    begin
        accepted_now = (start && !busy) || result_valid;
        if (!rst_n || accepted_now)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        row_t rows [$];
        row_t r;
        int   counts [8];
        int   src;
        mismatches    = 0;
        idle_cycles   = 0;
        seg_count_reg = 1;
        no_idle       = 1'b0;
        rst_n    <= 1'b0;
        start    <= 1'b0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        op       <= OP_LOAD;
        seg_slot <= '0;
        start_x  <= '0;
        start_y  <= '0;
        end_x    <= '0;
        end_y    <= '0;
        query_x  <= '0;
        query_y  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: degenerate segment, coordinate extremes, clamps at both ends, ties.
        rows = {rows, mk(-1, OP_LOAD, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, typed_q(768, 1024, 0, 0, 1638400, 1280)};
        rows = {rows, mk(-1, OP_LOAD, 0, -32768, -32768, 32767, 32767, 0, 0)};
        rows = {rows, typed_q(-32768, -32768, -32768, -32768, 0, 0)};
        rows = {rows, typed_q(32767, 32767, 32767, 32767, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 32767, -32768)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, -32768, 32767)};
        rows = {rows, mk(2, OP_LOAD, 1, 0, 0, 256, 0, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, -500, 77)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 1000, 5)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 100, 300)};
        rows = {rows, mk(-1, OP_LOAD, 0, 0, 0, 256, 0, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 128, -64)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, -1, -1)};
        rows = {rows, mk(-1, OP_LOAD, 1, 256, 256, 256, 256, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 256, 0)};
        rows = {rows, mk(-1, OP_LOAD, 0, -32768, 32767, 32767, -32768, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 0, 0)};
        rows = {rows, mk(-1, OP_QUERY, 0, 0, 0, 0, 0, 32767, 32767)};

        foreach (rows[i])
        begin
            if (rows[i].cnt_before >= 0)
                write_count(rows[i].cnt_before);
            send_transaction(rows[i]);
        end

        // Fill the whole table so any count is legal from here on.
        for (int s = 0; s < NSEG; s++)
        begin
            r = mk(-1, OP_LOAD, s, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                   0, 0);
            send_transaction(r);
        end

        // Count phases: zero and beyond-table saturation, both extremes, a few in between.
        counts = '{0, 127, 64, 3, 1, 17, 64, 2};
        foreach (counts[p])
        begin
            write_count(counts[p]);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 35; k++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    r = mk(-1, OP_LOAD, $urandom_range(0, NSEG - 1), pick_coord(),
                           pick_coord(), pick_coord(), pick_coord(), 0, 0);
                    // duplicate an existing segment now and then to force ties
                    if ($urandom_range(0, 3) == 0)
                    begin
                        src  = $urandom_range(0, 3);
                        r.sx = tbl_sx[src];
                        r.sy = tbl_sy[src];
                        r.ex = tbl_ex[src];
                        r.ey = tbl_ey[src];
                    end
                end
                else
                    r = mk(-1, OP_QUERY, 0, 0, 0, 0, 0, pick_coord(), pick_coord());
                send_transaction(r);
            end
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_hits.size() != 0 || busy);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
